>>> sv/fifo_queue_with_keyed_removal_unit_macros.svh
// Assertion macros shared by the keyed-removal queue RTL.
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FQKR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed in the same cycle");

// Next-cycle implication, checked on every rising edge outside reset.
`define FQKR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed one cycle later");

`endif

>>> sv/fqkr_pkg.sv
// Package with types and constants of the keyed-removal queue.
`default_nettype none
package fqkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_W       = 16;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PURGE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain in the cycle of a transfer.
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic             purge;
    logic [PID_W-1:0] key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/fqkr_if.sv
// Request and response channel interfaces of the keyed-removal queue.
`default_nettype none
interface fqkr_req_if;
  logic                          valid;
  logic                          ready;
  logic [fqkr_pkg::OP_W-1:0]     operation;
  logic [fqkr_pkg::PID_W-1:0]    pid;

  modport source (output valid, output operation, output pid, input ready);
  modport sink   (input valid, input operation, input pid, output ready);
endinterface

interface fqkr_rsp_if #(
  parameter int COUNT_W = fqkr_pkg::COUNT_W
);
  logic                            valid;
  logic                            ready;
  logic [fqkr_pkg::STATUS_W-1:0]   status;
  logic [fqkr_pkg::PID_W-1:0]      pid_out;
  logic [COUNT_W-1:0]              count;
  logic                            is_empty;

  modport source (output valid, output status, output pid_out, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input pid_out, input count,
                  input is_empty, output ready);
endinterface
`default_nettype wire

>>> sv/fifo_queue_with_keyed_removal_unit.sv
// Top level of the queue of process identifiers with removal by key.
// Latency: the response appears in the cycle after the request transfer.
// Throughput: one operation per cycle unless a response waits; the compare and
// hit ripple through the cell chain sets the clock period, one cell per entry.
// Reset: synchronous rst empties the queue and drops a pending response;
// entry data is not cleared, only the per-cell valid bits.
`default_nettype none
`include "fifo_queue_with_keyed_removal_unit_macros.svh"
module fifo_queue_with_keyed_removal_unit #(
  parameter int QUEUE_DEPTH = fqkr_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fqkr_req_if.sink    req,
  fqkr_rsp_if.source  rsp
);

  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  // Entries sit packed from cell 0 (the head) toward the tail; the valid bits
  // form a thermometer code, and the cell chain carries a hit flag from the
  // head so only the match nearest the head is removed.
  fqkr_pkg::cell_ctrl_t          ctrl;
  logic [QUEUE_DEPTH-1:0]        valid_vec;
  logic [fqkr_pkg::PID_W-1:0]    data_vec  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]        first_vec;
  logic [QUEUE_DEPTH:0]          hit_chain;
  logic [CountW-1:0]             occ;
  logic [CountW-1:0]             occ_next;
  logic                          accept;
  logic                          full;
  logic                          has_head;
  logic [fqkr_pkg::PID_W-1:0]    purge_pid;
  logic [fqkr_pkg::STATUS_W-1:0] status_next;
  logic [fqkr_pkg::PID_W-1:0]    pid_out_next;

  // The response register frees itself in the cycle it is taken, so a new
  // request transfer can follow every cycle.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full     = valid_vec[QUEUE_DEPTH-1];
  assign has_head = valid_vec[0];

  always_comb begin
    ctrl.enq   = accept && (req.operation == fqkr_pkg::OP_ENQ);
    ctrl.deq   = accept && (req.operation == fqkr_pkg::OP_DEQ);
    ctrl.purge = accept && (req.operation == fqkr_pkg::OP_PURGE);
    ctrl.key   = req.pid;
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                       prev_valid;
    logic                       next_valid;
    logic [fqkr_pkg::PID_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = valid_vec[i+1];
      assign next_data  = data_vec[i+1];
    end

    fqkr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_valid),
      .next_valid (next_valid),
      .next_data  (next_data),
      .hit_in     (hit_chain[i]),
      .valid      (valid_vec[i]),
      .data       (data_vec[i]),
      .hit_out    (hit_chain[i+1]),
      .first      (first_vec[i])
    );
  end

  // At most one cell flags the first match, so an OR over the gated entries
  // picks out the identifier being purged.
  always_comb begin
    purge_pid = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      purge_pid = purge_pid | (first_vec[i] ? data_vec[i] : '0);
    end
  end

  always_comb begin
    status_next  = fqkr_pkg::ST_OK;
    pid_out_next = '0;
    occ_next     = occ;
    unique case (req.operation)
      fqkr_pkg::OP_ENQ: begin
        if (full) begin
          status_next = fqkr_pkg::ST_FULL;
        end else begin
          occ_next = occ + CountW'(1);
        end
      end
      fqkr_pkg::OP_DEQ: begin
        if (!has_head) begin
          status_next = fqkr_pkg::ST_EMPTY;
        end else begin
          pid_out_next = data_vec[0];
          occ_next     = occ - CountW'(1);
        end
      end
      fqkr_pkg::OP_PURGE: begin
        if (!hit_chain[QUEUE_DEPTH]) begin
          status_next = fqkr_pkg::ST_NOTFOUND;
        end else begin
          pid_out_next = purge_pid;
          occ_next     = occ - CountW'(1);
        end
      end
      default: begin
        // The unused code leaves the queue alone and reports the occupancy.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        occ       <= occ_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status   <= status_next;
      rsp.pid_out  <= pid_out_next;
      rsp.count    <= occ_next;
      rsp.is_empty <= (occ_next == '0);
    end
  end

  // The occupancy counter and the valid thermometer must agree.
  `FQKR_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(valid_vec) == occ)
  // Entries stay packed toward the head.
  `FQKR_ASSERT_NOW(a_cells_packed, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // After any enqueue the queue cannot be empty.
  `FQKR_ASSERT_NEXT(a_enq_not_empty, ctrl.enq, rsp.valid && !rsp.is_empty)
  // The empty flag follows the reported count.
  `FQKR_ASSERT_NOW(a_empty_flag, rsp.valid, rsp.is_empty == (rsp.count == '0))

endmodule
`default_nettype wire

>>> sv/fqkr_cell.sv
// One slot of the queue: holds an entry, compares it and shifts toward the head.
`default_nettype none
module fqkr_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fqkr_pkg::cell_ctrl_t        ctrl,
  input  wire logic                        prev_valid,
  input  wire logic                        next_valid,
  input  wire logic [fqkr_pkg::PID_W-1:0]  next_data,
  input  wire logic                        hit_in,
  output logic                             valid,
  output logic [fqkr_pkg::PID_W-1:0]       data,
  output logic                             hit_out,
  output logic                             first
);

  logic match;
  logic shift;
  logic load;

  always_comb begin
    match   = ctrl.purge && valid && (data == ctrl.key);
    first   = match && !hit_in;
    hit_out = hit_in || match;
    // Every cell at or behind the removed slot takes its neighbor's entry.
    shift   = ctrl.deq || (ctrl.purge && hit_out);
    // The first empty slot takes a new entry.
    load    = ctrl.enq && !valid && prev_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= next_data;
    end else if (load) begin
      data <= ctrl.key;
    end
  end

endmodule
`default_nettype wire
